### rtl/sdc_pkg.sv
// shared constants, types and reset-pattern function for the sd card register model
`timescale 1ns / 1ps
`default_nettype none
package sdc_pkg;

	// bus and register space geometry
	localparam int BUS_BYTES       = 8;
	localparam int ROW_BYTES       = 8;
	localparam int ROW_BITS        = 8 * ROW_BYTES;
	localparam int REG_SPACE_BYTES = 1024;
	localparam int RS_ROWS         = REG_SPACE_BYTES / ROW_BYTES;
	localparam int RS_ROW_W        = $clog2(RS_ROWS);
	localparam int SECTOR_BYTES    = 512;
	localparam int SEC_SHIFT       = $clog2(SECTOR_BYTES);
	localparam int BUF_ROWS        = SECTOR_BYTES / ROW_BYTES;
	localparam int SEC_ROW_W       = $clog2(BUF_ROWS);
	localparam int CNT_W           = SEC_ROW_W + 1;
	localparam longint unsigned CARD_BYTES_DEF = 64'd1048576;
	localparam int UNIT_SHIFT      = 19;
	localparam int SIZE_W          = 13;
	localparam logic [7:0] FILL_BYTE = 8'hab;

	// register offsets
	localparam int OFS_CSD    = 528;
	localparam int OFS_ARG    = 556;
	localparam int OFS_CMD    = 560;
	localparam int OFS_STATUS = 564;
	localparam int OFS_RESP   = 568;

	localparam logic [RS_ROW_W-1:0] CSD_ROW0   = RS_ROW_W'(OFS_CSD / ROW_BYTES);
	localparam logic [RS_ROW_W-1:0] CSD_ROW1   = RS_ROW_W'(OFS_CSD / ROW_BYTES + 1);
	localparam logic [RS_ROW_W-1:0] ARG_ROW    = RS_ROW_W'(OFS_ARG / ROW_BYTES);
	localparam logic [RS_ROW_W-1:0] CMD_ROW    = RS_ROW_W'(OFS_CMD / ROW_BYTES);
	localparam logic [RS_ROW_W-1:0] STATUS_ROW = RS_ROW_W'(OFS_STATUS / ROW_BYTES);
	localparam logic [RS_ROW_W-1:0] RESP_ROW   = RS_ROW_W'(OFS_RESP / ROW_BYTES);
	localparam int ARG_LANE    = OFS_ARG % ROW_BYTES;
	localparam int CMD_LANE    = OFS_CMD % ROW_BYTES;
	localparam int STATUS_LANE = OFS_STATUS % ROW_BYTES;
	localparam int RESP_LANE   = OFS_RESP % ROW_BYTES;

	// command codes and status / response bits
	localparam logic [15:0] CMD_RD      = 16'h0011;
	localparam logic [15:0] CMD_WR      = 16'h0018;
	localparam logic [15:0] ST_VALID    = 16'h0001;
	localparam logic [15:0] ST_PRESENT  = 16'h0002;
	localparam logic [15:0] ST_DATAERR  = 16'h0020;
	localparam logic [15:0] R1_NONE     = 16'h0000;
	localparam logic [15:0] R1_ILLEGAL  = 16'h0400;
	localparam logic [15:0] R1_MISALIGN = 16'h1000;
	localparam logic [15:0] R1_RANGE    = 16'h2000;

	// configuration register indexes and request codes
	localparam logic CFG_CARD_SIZE = 1'b0;
	localparam logic CFG_WRITE_PROT = 1'b1;
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	typedef enum logic [2:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_RD_ARG,
		SQ_RD_CMD,
		SQ_DECIDE,
		SQ_COPY,
		SQ_WR_STATUS,
		SQ_WR_RESP
	} seq_state_t;

	typedef struct packed {
		logic                  we;
		logic [RS_ROW_W-1:0]   row;
		logic [ROW_BYTES-1:0]  be;
		logic [ROW_BITS-1:0]   data;
	} rs_wr_t;

	typedef struct packed {
		logic                en;
		logic [RS_ROW_W-1:0] row;
	} rs_rd_t;

	// contents of a row that was never written since reset or csd reload
	function automatic logic [ROW_BITS-1:0] rs_reset_row(input logic [RS_ROW_W-1:0] row,
		input logic [SIZE_W-1:0] units);
		logic [11:0]         c;
		logic [SIZE_W-1:0]   cm1;
		logic [ROW_BITS-1:0] r;
		cm1 = units - SIZE_W'(1);
		c = cm1[11:0];
		r = '0;
		case (row)
			CSD_ROW0: begin
				r[8*5 +: 8] = 8'h80;
				r[8*6 +: 8] = 8'h03;
				r[8*7 +: 8] = {c[1:0], 6'b0};
			end
			CSD_ROW1: begin
				r[8*0 +: 8] = c[9:2];
				r[8*1 +: 8] = {6'b0, c[11:10]};
				r[8*2 +: 8] = 8'd10;
			end
			STATUS_ROW: begin
				r[8*STATUS_LANE +: 16] = ST_PRESENT;
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/sdc_reg_space.sv
// register space memory: 8-byte rows, byte writes, registered read, per-row valid bits
`timescale 1ns / 1ps
`default_nettype none
module sdc_reg_space import sdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  rs_wr_t              wr,
	input  rs_rd_t              rd,
	input  logic                csd_reload,
	input  logic [SIZE_W-1:0]   card_size,
	output logic [ROW_BITS-1:0] rd_data
);

	logic [ROW_BITS-1:0] mem [RS_ROWS];
	logic [RS_ROWS-1:0]  valid_q;
	logic [ROW_BITS-1:0] mem_s1;
	logic [RS_ROW_W-1:0] rd_row_s1;
	logic                rd_vld_s1;
	logic [ROW_BYTES-1:0] eff_be;
	logic [ROW_BITS-1:0]  eff_data;
	logic [ROW_BITS-1:0]  base_row;

	// a first write to a row fills the untouched lanes with the reset pattern
	always_comb begin
		base_row = rs_reset_row(wr.row, card_size);
		eff_be   = valid_q[wr.row] ? wr.be : '1;
		for (int i = 0; i < ROW_BYTES; i++) begin
			eff_data[8*i +: 8] = wr.be[i] ? wr.data[8*i +: 8] : base_row[8*i +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			for (int i = 0; i < ROW_BYTES; i++) begin
				if (eff_be[i]) begin
					mem[wr.row][8*i +: 8] <= eff_data[8*i +: 8];
				end
			end
		end
		if (rd.en) begin
			mem_s1    <= mem[rd.row];
			rd_row_s1 <= rd.row;
			rd_vld_s1 <= valid_q[rd.row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (wr.we) begin
				valid_q[wr.row] <= 1'b1;
			end
			// csd rows fall back to the pattern built from the new size
			if (csd_reload) begin
				valid_q[CSD_ROW0] <= 1'b0;
				valid_q[CSD_ROW1] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_vld_s1 ? mem_s1 : rs_reset_row(rd_row_s1, card_size);

endmodule
`default_nettype wire

### rtl/sdc_card_mem.sv
// card contents memory with a zeroing pass after reset
`timescale 1ns / 1ps
`default_nettype none
module sdc_card_mem import sdc_pkg::*; #(
	parameter longint unsigned CARD_BYTES = CARD_BYTES_DEF,
	parameter int ADDR_W = $clog2(CARD_BYTES / 8)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic                re,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [ROW_BITS-1:0] wdata,
	output logic [ROW_BITS-1:0] rdata,
	output logic                ready
);

	localparam int WORDS = int'(CARD_BYTES / 8);

	logic [ROW_BITS-1:0] mem [WORDS];
	logic [ROW_BITS-1:0] rdata_s1;
	logic                clr_act_q;
	logic [ADDR_W-1:0]   clr_idx_q;

	always_ff @(posedge clk) begin
		if (clr_act_q) begin
			mem[clr_idx_q] <= '0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_act_q) begin
			if (clr_idx_q == ADDR_W'(WORDS - 1)) begin
				clr_act_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + ADDR_W'(1);
		end
	end

	assign rdata = rdata_s1;
	assign ready = !clr_act_q;

endmodule
`default_nettype wire

### rtl/sd_card_block_register_model.sv
// sd card register window: top level with command sequencer and fetch output stage
//
// bus side: request channel (in_valid / in_ready) carries store and fetch
// beats of one 8-byte word; response channel (out_valid / out_ready) returns
// one beat per fetch, disabled lanes filled with 0xab; stores return nothing.
// a fetch response passes the register space read register, then the output
// register; fetches stream at one per cycle while out_ready is high and the
// sequencer idles, and the next request is still taken while one response waits there.
// a store that writes the command byte starts the command sequencer: arg read,
// command read, decide, status write and response write for a command that
// moves no data, with the 64-word sector copy after decide for a block read or
// write that passes its checks; the copy runs through the single port of the
// card memory and the single write port of the register space.
// requests are held off while the sequencer runs.
// reset: the card memory is zeroed one word per cycle, all CARD_BYTES/8 words
// (131072 at the default size), before the first request is taken; config
// writes are taken during that pass. status and csd come from per-row valid bits.
// a stalled response side holds the output register and one fetch behind it,
// then no further request of either kind is taken until it drains.
`timescale 1ns / 1ps
`default_nettype none
module sd_card_block_register_model import sdc_pkg::*; #(
	parameter longint unsigned CARD_BYTES = CARD_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	// request beats
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [6:0]        word_addr,
	input  logic [7:0]        byte_enable,
	input  logic [63:0]       write_data,
	// response beats
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       read_data
);

	localparam int ADDR_W = $clog2(CARD_BYTES / 8);
	localparam logic [ROW_BYTES-1:0] LANE_MASK = ROW_BYTES'((9'd1 << BUS_BYTES) - 9'd1);
	localparam logic [32:0] CARD_LIMIT = 33'(CARD_BYTES);

	seq_state_t state_q, state_nx;

	// configuration registers
	logic [SIZE_W-1:0] card_size_q;
	logic              wp_q;

	// sequencer registers
	logic [31:0]       arg_q;
	logic [15:0]       status_q;
	logic [15:0]       resp_q;
	logic              copy_q;
	logic              to_card_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SEC_ROW_W-1:0] cnt_m1;

	// fetch path
	logic              pend_s1;
	logic [7:0]        fetch_be_s1;
	logic              out_valid_q;
	logic [63:0]       out_data_q;
	logic [63:0]       fetch_word;
	logic              out_load;

	// handshake
	logic              acc;
	logic [7:0]        be_m;
	logic              cmd_hit;

	// memory side
	rs_wr_t            rs_wr;
	rs_rd_t            rs_rd;
	logic [ROW_BITS-1:0] rs_rd_data;
	logic              card_we;
	logic              card_re;
	logic [ADDR_W-1:0] card_addr;
	logic [ROW_BITS-1:0] card_wdata;
	logic [ROW_BITS-1:0] card_rdata;
	logic              card_ready;

	// command decision
	logic [15:0]       dec_cmd;
	logic [15:0]       dec_st;
	logic [15:0]       dec_status;
	logic [15:0]       dec_resp;
	logic              dec_copy;
	logic              dec_to_card;
	logic              misalign;
	logic              out_of_range;
	logic [32:0]       unit_limit;
	logic [32:0]       limit;
	logic [32:0]       arg_end;
	logic [ADDR_W-SEC_ROW_W-1:0] card_base;

	sdc_reg_space u_reg_space (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (rs_wr),
		.rd         (rs_rd),
		.csd_reload (cfg_write && (cfg_index == CFG_CARD_SIZE)),
		.card_size  (card_size_q),
		.rd_data    (rs_rd_data)
	);

	sdc_card_mem #(
		.CARD_BYTES (CARD_BYTES),
		.ADDR_W     (ADDR_W)
	) u_card_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (card_we),
		.re     (card_re),
		.addr   (card_addr),
		.wdata  (card_wdata),
		.rdata  (card_rdata),
		.ready  (card_ready)
	);

	// output register frees when empty or drained this cycle
	assign out_load = pend_s1 && (!out_valid_q || out_ready);
	assign in_ready = (state_q == SQ_IDLE) && (!pend_s1 || out_load);
	assign acc      = in_valid && in_ready;
	assign be_m     = byte_enable & LANE_MASK;
	assign cmd_hit  = (word_addr == CMD_ROW) && be_m[CMD_LANE];

	assign cnt_m1    = cnt_q[SEC_ROW_W-1:0] - SEC_ROW_W'(1);
	assign card_base = arg_q[SEC_SHIFT +: ADDR_W - SEC_ROW_W];

	// fill disabled lanes of a fetched row
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			fetch_word[8*i +: 8] = fetch_be_s1[i] ? rs_rd_data[8*i +: 8] : FILL_BYTE;
		end
	end

	// command decode, valid in the cycle the command row arrives
	always_comb begin
		dec_cmd      = rs_rd_data[8*CMD_LANE +: 16];
		dec_st       = rs_rd_data[8*STATUS_LANE +: 16];
		misalign     = |arg_q[SEC_SHIFT-1:0];
		unit_limit   = {1'b0, card_size_q, UNIT_SHIFT'(0)};
		limit        = (unit_limit > CARD_LIMIT) ? CARD_LIMIT : unit_limit;
		arg_end      = {1'b0, arg_q} + 33'(SECTOR_BYTES);
		out_of_range = arg_end > limit;
		dec_copy     = 1'b0;
		dec_to_card  = 1'b0;
		dec_status   = dec_st & ~ST_VALID;
		dec_resp     = R1_ILLEGAL;
		if (dec_cmd == CMD_RD || dec_cmd == CMD_WR) begin
			if (misalign) begin
				dec_status = (dec_st & ~ST_VALID) | ST_DATAERR;
				dec_resp   = R1_MISALIGN;
			end else if (out_of_range) begin
				dec_status = (dec_st & ~ST_VALID) | ST_DATAERR;
				dec_resp   = R1_RANGE;
			end else if (dec_cmd == CMD_WR && wp_q) begin
				dec_status = dec_st & ~ST_VALID;
				dec_resp   = R1_ILLEGAL;
			end else if (dec_cmd == CMD_WR) begin
				dec_copy    = 1'b1;
				dec_to_card = 1'b1;
				dec_status  = dec_st | ST_VALID | ST_DATAERR;
				dec_resp    = R1_NONE;
			end else begin
				dec_copy   = 1'b1;
				dec_status = (dec_st & ~ST_DATAERR) | ST_VALID;
				dec_resp   = R1_NONE;
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			SQ_CLEAR: begin
				if (card_ready) begin
					state_nx = SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				if (acc && req_type == REQ_STORE && cmd_hit) begin
					state_nx = SQ_RD_ARG;
				end
			end
			SQ_RD_ARG: state_nx = SQ_RD_CMD;
			SQ_RD_CMD: state_nx = SQ_DECIDE;
			SQ_DECIDE: state_nx = dec_copy ? SQ_COPY : SQ_WR_STATUS;
			SQ_COPY: begin
				if (cnt_q == CNT_W'(BUF_ROWS)) begin
					state_nx = SQ_WR_STATUS;
				end
			end
			SQ_WR_STATUS: state_nx = SQ_WR_RESP;
			SQ_WR_RESP: state_nx = SQ_IDLE;
			default: state_nx = SQ_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		rs_wr      = '0;
		rs_rd      = '0;
		card_we    = 1'b0;
		card_re    = 1'b0;
		card_addr  = '0;
		card_wdata = rs_rd_data;
		case (state_q)
			SQ_IDLE: begin
				if (acc && req_type == REQ_STORE) begin
					rs_wr.we   = 1'b1;
					rs_wr.row  = word_addr;
					rs_wr.be   = be_m;
					rs_wr.data = write_data;
				end
				if (acc && req_type == REQ_FETCH) begin
					rs_rd.en  = 1'b1;
					rs_rd.row = word_addr;
				end
			end
			SQ_RD_ARG: begin
				rs_rd.en  = 1'b1;
				rs_rd.row = ARG_ROW;
			end
			SQ_RD_CMD: begin
				rs_rd.en  = 1'b1;
				rs_rd.row = CMD_ROW;
			end
			SQ_COPY: begin
				if (to_card_q) begin
					// buffer row k read now, written to the card in the next cycle
					rs_rd.en  = cnt_q < CNT_W'(BUF_ROWS);
					rs_rd.row = RS_ROW_W'(cnt_q[SEC_ROW_W-1:0]);
					card_we   = cnt_q != '0;
					card_addr = {card_base, cnt_m1};
				end else begin
					// card word k read now, lands in buffer row k in the next cycle
					card_re    = cnt_q < CNT_W'(BUF_ROWS);
					card_addr  = {card_base, cnt_q[SEC_ROW_W-1:0]};
					rs_wr.we   = cnt_q != '0;
					rs_wr.row  = RS_ROW_W'(cnt_m1);
					rs_wr.be   = '1;
					rs_wr.data = card_rdata;
				end
			end
			SQ_WR_STATUS: begin
				rs_wr.we   = 1'b1;
				rs_wr.row  = STATUS_ROW;
				rs_wr.be   = ROW_BYTES'(2'b11) << STATUS_LANE;
				rs_wr.data = ROW_BITS'(status_q) << (8 * STATUS_LANE);
			end
			SQ_WR_RESP: begin
				rs_wr.we   = 1'b1;
				rs_wr.row  = RESP_ROW;
				rs_wr.be   = ROW_BYTES'(2'b11) << RESP_LANE;
				rs_wr.data = ROW_BITS'(resp_q) << (8 * RESP_LANE);
			end
			default: begin
				rs_wr = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_CLEAR;
			card_size_q <= SIZE_W'(2);
			wp_q        <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			copy_q      <= 1'b0;
			to_card_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_write) begin
				if (cfg_index == CFG_CARD_SIZE) begin
					card_size_q <= cfg_data;
				end else begin
					wp_q <= cfg_data[0];
				end
			end
			// fetch stage and output register
			if (acc && req_type == REQ_FETCH) begin
				pend_s1 <= 1'b1;
			end else if (out_load) begin
				pend_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// sector copy counter
			if (state_q == SQ_DECIDE) begin
				cnt_q     <= '0;
				copy_q    <= dec_copy;
				to_card_q <= dec_to_card;
			end else if (state_q == SQ_COPY) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc && req_type == REQ_FETCH) begin
			fetch_be_s1 <= be_m;
		end
		if (out_load) begin
			out_data_q <= fetch_word;
		end
		if (state_q == SQ_RD_CMD) begin
			arg_q <= rs_rd_data[8*ARG_LANE +: 32];
		end
		if (state_q == SQ_DECIDE) begin
			status_q <= dec_status;
			resp_q   <= dec_resp;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;

	// a store to the command byte always launches the sequencer
	a_cmd_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req_type == REQ_STORE && cmd_hit |=> state_q == SQ_RD_ARG)
		else $error("command store did not start the sequencer");

	// a fetch waiting on a full output register is kept
	a_fetch_kept: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && !out_load |=> pend_s1 && $stable(fetch_be_s1))
		else $error("pending fetch lost");

	// copy runs only when the decision asked for it and stays in bounds
	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_COPY |-> copy_q && cnt_q <= CNT_W'(BUF_ROWS))
		else $error("sector copy out of bounds");

	// no card access from the sequencer and no request taken while the zeroing pass runs
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!card_ready |-> !card_we && !card_re && !in_ready)
		else $error("card access during clearing pass");

endmodule
`default_nettype wire

### tb/sd_card_block_register_model_tb.sv
// self-checking testbench for the sd card register window: predicts fetch data and checks it
`timescale 1ns / 1ps
module sd_card_block_register_model_tb;
	import sdc_pkg::*;

	// wait after the last fetch returns, long enough for a block command to finish
	localparam int SETTLE_CYCLES = 100;
	// watchdog limit on quiet cycles; it must outlast the card memory clearing pass after reset
	localparam int STALL_LIMIT   = 400000;
	// length of the long response-side hold that backs up the request side
	localparam int LONG_HOLD     = 48;
	localparam int PHASE_BEATS   = 185;
	localparam int PHASES        = 9;

	// register window tracker: own copy of the byte space, card and settings,
	// plus the fetch words still owed by the block
	class card_window_tracker;
		logic [7:0]  win [REG_SPACE_BYTES];
		bit   [63:0] card_words [int unsigned];
		bit   [12:0] units;
		bit          wp;
		logic [63:0] fetch_words_due [$];
		int          mismatch_count;

		function new();
			for (int i = 0; i < REG_SPACE_BYTES; i++)
				win[i] = 8'h00;
			units = 13'd2;
			wp = 1'b0;
			mismatch_count = 0;
			put16(OFS_STATUS, ST_PRESENT);
			reload_csd();
		endfunction

		function logic [15:0] get16(int ofs);
			return {win[ofs + 1], win[ofs]};
		endfunction

		function void put16(int ofs, logic [15:0] v);
			win[ofs] = v[7:0];
			win[ofs + 1] = v[15:8];
		endfunction

		function void adjust_status(logic [15:0] clr, logic [15:0] set);
			put16(OFS_STATUS, (get16(OFS_STATUS) & ~clr) | set);
		endfunction

		// csd pattern with c_size taken from the card size setting
		function void reload_csd();
			bit [12:0] m;
			bit [11:0] c;
			m = units - 13'd1;
			c = m[11:0];
			for (int i = 0; i < 16; i++)
				win[OFS_CSD + i] = 8'h00;
			win[OFS_CSD + 5] = 8'h80;
			win[OFS_CSD + 6] = 8'h03;
			win[OFS_CSD + 7] = {c[1:0], 6'b0};
			win[OFS_CSD + 8] = c[9:2];
			win[OFS_CSD + 9] = {6'b0, c[11:10]};
			win[OFS_CSD + 10] = 8'd10;
		endfunction

		function void write_setting(logic idx, bit [12:0] v);
			if (idx == CFG_CARD_SIZE) begin
				units = v;
				reload_csd();
			end else begin
				wp = v[0];
			end
		endfunction

		// alignment first, then range without wrap
		function bit arg_ok(logic [31:0] arg);
			longint unsigned span;
			span = longint'(units) << UNIT_SHIFT;
			if (span > CARD_BYTES_DEF)
				span = CARD_BYTES_DEF;
			if (arg[SEC_SHIFT-1:0] != '0) begin
				adjust_status(ST_VALID, ST_DATAERR);
				put16(OFS_RESP, R1_MISALIGN);
				return 1'b0;
			end
			if (longint'(arg) + SECTOR_BYTES > span) begin
				adjust_status(ST_VALID, ST_DATAERR);
				put16(OFS_RESP, R1_RANGE);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void move_sector(logic [31:0] arg, bit to_card);
			int unsigned w;
			bit [63:0]   v;
			for (int k = 0; k < BUF_ROWS; k++) begin
				w = (arg >> 3) + k;
				if (w >= CARD_BYTES_DEF / 8)
					break;
				if (to_card) begin
					for (int b = 0; b < 8; b++)
						v[8*b +: 8] = win[k*8 + b];
					card_words[w] = v;
				end else begin
					v = card_words.exists(w) ? card_words[w] : 64'h0;
					for (int b = 0; b < 8; b++)
						win[k*8 + b] = v[8*b +: 8];
				end
			end
		endfunction

		function void decode_command();
			logic [15:0] code;
			logic [31:0] arg;
			code = get16(OFS_CMD);
			arg = {win[OFS_ARG + 3], win[OFS_ARG + 2], win[OFS_ARG + 1], win[OFS_ARG]};
			if (code == CMD_RD) begin
				if (!arg_ok(arg))
					return;
				move_sector(arg, 1'b0);
				adjust_status(ST_DATAERR, ST_VALID);
				put16(OFS_RESP, R1_NONE);
			end else if (code == CMD_WR) begin
				if (!arg_ok(arg))
					return;
				if (wp) begin
					adjust_status(ST_VALID, 16'h0);
					put16(OFS_RESP, R1_ILLEGAL);
					return;
				end
				move_sector(arg, 1'b1);
				adjust_status(16'h0, ST_VALID | ST_DATAERR);
				put16(OFS_RESP, R1_NONE);
			end else begin
				adjust_status(ST_VALID, 16'h0);
				put16(OFS_RESP, R1_ILLEGAL);
			end
		endfunction

		function void note_request(logic rt, logic [6:0] wa, logic [7:0] be, logic [63:0] wd);
			int          a;
			bit          hit;
			logic [63:0] r;
			hit = 1'b0;
			if (rt == REQ_STORE) begin
				for (int i = 0; i < BUS_BYTES; i++) begin
					a = (int'(wa) * BUS_BYTES + i) % REG_SPACE_BYTES;
					if (be[i]) begin
						win[a] = wd[8*i +: 8];
						if (a == OFS_CMD)
							hit = 1'b1;
					end
				end
				if (hit)
					decode_command();
			end else begin
				for (int i = 0; i < 8; i++) begin
					a = (int'(wa) * BUS_BYTES + i) % REG_SPACE_BYTES;
					r[8*i +: 8] = (i < BUS_BYTES && be[i]) ? win[a] : FILL_BYTE;
				end
				fetch_words_due.push_back(r);
			end
		endfunction

		function void check_fetch(logic [63:0] got);
			logic [63:0] want;
			if (fetch_words_due.size() == 0) begin
				$display("%0t: read_data with no fetch pending, expected none, got %h",
					$time, got);
				mismatch_count++;
			end else begin
				want = fetch_words_due.pop_front();
				if (got !== want) begin
					$display("%0t: read_data mismatch, expected %h, got %h", $time, want, got);
					mismatch_count++;
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic              cfg_index;
	logic [SIZE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              req_type;
	logic [6:0]        word_addr;
	logic [7:0]        byte_enable;
	logic [63:0]       write_data;
	logic              out_valid;
	logic              out_ready;
	logic [63:0]       read_data;

	card_window_tracker tracker;
	int  beats_sent = 0;
	int  quiet_cycles = 0;
	// idle odds in percent per beat, one for each side
	int  gap_pct = 0;
	int  stall_pct = 0;
	// asks the response side for one long hold
	bit  long_hold_req = 1'b0;

	sd_card_block_register_model dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.word_addr  (word_addr),
		.byte_enable(byte_enable),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// monitor: both channels sampled at the rising edge, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_request(req_type, word_addr, byte_enable, write_data);
			if (out_valid && out_ready)
				tracker.check_fetch(read_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("sd_card_block_register_model_tb: done, errors");
				$finish;
			end
		end
	end

	// response side: random short stalls, and one long hold when asked
	initial begin : response_side
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				hold = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one request beat; valid stays up from beat to beat unless a gap is drawn
	task automatic send_beat(input logic rt, input logic [6:0] wa, input logic [7:0] be,
		input logic [63:0] wd);
		int gap;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			gap = $urandom_range(1, 7);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rt;
		word_addr <= wa;
		byte_enable <= be;
		write_data <= wd;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// settings only change while nothing is in flight
	task automatic apply_setting(input logic idx, input logic [SIZE_W-1:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		tracker.write_setting(idx, v);
	endtask

	// argument, command byte, then read back status and r1
	task automatic run_block_cmd(input logic [15:0] code, input logic [31:0] arg);
		send_beat(REQ_STORE, ARG_ROW, 8'hf << ARG_LANE, 64'(arg) << (8 * ARG_LANE));
		send_beat(REQ_STORE, CMD_ROW, 8'h3 << CMD_LANE, 64'(code) << (8 * CMD_LANE));
		send_beat(REQ_FETCH, STATUS_ROW, 8'hff, 64'h0);
		send_beat(REQ_FETCH, RESP_ROW, 8'hff, 64'h0);
	endtask

	// stop offering, let every fetch come back, then wait out a running command
	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.fetch_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// card offsets: mostly a few sectors that get reused, so writes are read back;
	// the rest a random sector of the card, misaligned, beyond the card, or fully random
	function automatic logic [31:0] pick_card_offset();
		int unsigned sel;
		int unsigned sector;
		int unsigned pool [6] = '{0, 1, 5, 1023, 1024, 2047};
		sel = $urandom_range(0, 9);
		sector = pool[$urandom_range(0, 5)];
		if (sel <= 5)
			return 32'(sector) << SEC_SHIFT;
		else if (sel == 6)
			return 32'($urandom_range(0, 2047)) << SEC_SHIFT;
		else if (sel == 7)
			return (32'(sector) << SEC_SHIFT) | 32'($urandom_range(1, SECTOR_BYTES - 1));
		else if (sel == 8)
			return 32'($urandom_range(2048, 8191)) << SEC_SHIFT;
		else
			return $urandom();
	endfunction

	task automatic random_item();
		int unsigned pick;
		int unsigned n;
		logic [15:0] code;
		logic [7:0]  be;
		pick = $urandom_range(0, 99);
		be = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hff;
		if (pick < 30) begin
			// block command, mostly read or write, with random content around it
			n = $urandom_range(0, 99);
			code = (n < 45) ? CMD_RD : (n < 90) ? CMD_WR : 16'($urandom);
			if (code == CMD_WR)
				repeat ($urandom_range(1, 3))
					send_beat(REQ_STORE, 7'($urandom_range(0, BUF_ROWS - 1)), 8'hff,
						{$urandom, $urandom});
			run_block_cmd(code, pick_card_offset());
			if (code == CMD_RD)
				repeat ($urandom_range(1, 2))
					send_beat(REQ_FETCH, 7'($urandom_range(0, BUF_ROWS - 1)), be,
						{$urandom, $urandom});
		end else if (pick < 55) begin
			send_beat(REQ_STORE, 7'($urandom_range(0, BUF_ROWS - 1)), be, {$urandom, $urandom});
		end else if (pick < 80) begin
			send_beat(REQ_FETCH, 7'($urandom), be, {$urandom, $urandom});
		end else if (pick < 90) begin
			// noise: any word, any lanes, may hit csd, status or the command byte
			send_beat(REQ_STORE, 7'($urandom), 8'($urandom), {$urandom, $urandom});
		end else begin
			send_beat(REQ_FETCH, 7'(CSD_ROW0 + $urandom_range(0, RESP_ROW - CSD_ROW0)), be,
				{$urandom, $urandom});
		end
	endtask

	initial begin : stimulus
		bit [12:0] size_plan [PHASES] = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd2, 13'd3,
			13'd0, 13'd0, 13'd2};
		bit        wp_plan [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
		int        phase_end;
		int        saved_gap;

		tracker = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_CARD_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_STORE;
		word_addr = '0;
		byte_enable = '0;
		write_data = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset pattern, lane extremes, every command outcome
		gap_pct = 15;
		stall_pct = 15;
		send_beat(REQ_FETCH, CSD_ROW0, 8'hff, 64'h0);
		send_beat(REQ_FETCH, CSD_ROW1, 8'hff, 64'h0);
		// no lanes enabled: every byte reads as fill
		send_beat(REQ_FETCH, 7'd0, 8'h00, 64'hffff_ffff_ffff_ffff);
		send_beat(REQ_STORE, 7'd0, 8'hff, 64'hffff_ffff_ffff_ffff);
		send_beat(REQ_STORE, 7'd127, 8'ha5, 64'h0123_4567_89ab_cdef);
		send_beat(REQ_FETCH, 7'd0, 8'hff, 64'h0);
		send_beat(REQ_FETCH, 7'd127, 8'hff, 64'h0);
		// buffer to card, then a blank sector back over the buffer
		run_block_cmd(CMD_WR, 32'(SECTOR_BYTES));
		run_block_cmd(CMD_RD, 32'h0);
		send_beat(REQ_FETCH, 7'd0, 8'hff, 64'h0);
		// misaligned, past the end of the card, unknown command
		run_block_cmd(CMD_RD, 32'h104);
		run_block_cmd(CMD_RD, 32'h0010_0000);
		run_block_cmd(16'h0005, 32'h0);
		// status bytes are writable even though the card owns them
		send_beat(REQ_STORE, STATUS_ROW, 8'h3 << STATUS_LANE, 64'hffff << (8 * STATUS_LANE));
		send_beat(REQ_FETCH, STATUS_ROW, 8'hff, 64'h0);
		drain_and_settle();

		// random phases, each under its own card size and protect setting
		for (int p = 0; p < PHASES; p++) begin
			if (p == 6 || p == 7) begin
				size_plan[p] = 13'($urandom_range(1, 8191));
				wp_plan[p] = 1'($urandom);
			end
			apply_setting(CFG_CARD_SIZE, size_plan[p]);
			apply_setting(CFG_WRITE_PROT, SIZE_W'(wp_plan[p]));
			// last phase runs flat out; others mix idle and busy stretches
			gap_pct = (p == PHASES - 1 || p % 3 == 2) ? 0 : 20;
			stall_pct = (p == PHASES - 1 || p % 3 == 1) ? 0 : 20;
			phase_end = beats_sent + PHASE_BEATS;
			if (p == 1 || p == 4) begin
				// response side holds off while fetches keep coming
				saved_gap = gap_pct;
				gap_pct = 0;
				long_hold_req = 1'b1;
				repeat (24)
					send_beat(REQ_FETCH, 7'($urandom), 8'($urandom), {$urandom, $urandom});
				gap_pct = saved_gap;
			end
			while (beats_sent < phase_end)
				random_item();
			drain_and_settle();
		end

		if (tracker.mismatch_count == 0)
			$display("sd_card_block_register_model_tb: done, clean");
		else
			$display("sd_card_block_register_model_tb: done, errors");
		$finish;
	end

endmodule

### sd_card_block_register_model.f
rtl/sdc_pkg.sv
rtl/sdc_reg_space.sv
rtl/sdc_card_mem.sv
rtl/sd_card_block_register_model.sv
tb/sd_card_block_register_model_tb.sv
